FILE: rtl/core/odo_pkg.sv
// Shared types, constants and tables of the odometry update unit.
package odo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ROT_CNT_W    = $clog2(CORDIC_STEPS);
	localparam int VEC_W        = 46;
	localparam int ANG_W        = 32;
	localparam int MUL_A_W      = 46;
	localparam int MUL_B_W      = 32;
	localparam int MUL_CNT_W    = $clog2(MUL_B_W);
	localparam int PROD_W       = MUL_A_W + MUL_B_W;
	localparam int POS_W        = 48;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSS_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_VY_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 3'd3;

	localparam logic [31:0] YAW_GAIN_RST     = 32'd15270995;
	localparam logic [15:0] CROSS_GAIN_RST   = 16'd37837;
	localparam logic [15:0] YAW_VY_GAIN_RST  = 16'd16156;
	localparam logic [31:0] PULSE_LENGTH_RST = 32'd404791;
	localparam logic [31:0] GAIN_COMP        = 32'd2608131496;

	typedef struct packed {
		logic signed [15:0] count_a;
		logic signed [15:0] count_b;
		logic signed [23:0] gyro_rate;
	} odo_in_t;

	typedef struct packed {
		logic signed [47:0] x_pos;
		logic signed [47:0] y_pos;
		logic [31:0]        heading;
	} odo_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Rotation angle of step i, full turn = 2^32.
	function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
		logic [ANG_W-1:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/odo_ser_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
module odo_ser_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [odo_pkg::MUL_A_W-1:0]   a,
	input  logic [odo_pkg::MUL_B_W-1:0]   b,
	output odo_pkg::unit_stat_t           stat,
	output logic [odo_pkg::PROD_W-1:0]    prod
);
	import odo_pkg::*;

	localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_A_W-1:0]   hi_q;
	logic [MUL_B_W-1:0]   lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [MUL_A_W:0]     sum;

	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add, then shift the partial product one place right.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (run_q) begin
			b_q  <= b_q >> 1;
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign prod      = {hi_q, lo_q};

endmodule

FILE: rtl/core/odo_cordic.sv
// Iterative CORDIC rotator with quarter-turn pre-rotation.
module odo_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [odo_pkg::ANG_W-1:0]         angle,
	input  logic signed [odo_pkg::VEC_W-1:0]  x_in,
	input  logic signed [odo_pkg::VEC_W-1:0]  y_in,
	output odo_pkg::unit_stat_t               stat,
	output logic signed [odo_pkg::VEC_W-1:0]  x_out,
	output logic signed [odo_pkg::VEC_W-1:0]  y_out
);
	import odo_pkg::*;

	localparam logic [ROT_CNT_W-1:0] LAST = ROT_CNT_W'(CORDIC_STEPS - 1);

	logic signed [VEC_W-1:0] x_q, y_q, xs, ys, x0, y0;
	logic signed [ANG_W-1:0] z_q;
	logic [ANG_W-1:0]        hq, d, at;
	logic [1:0]              q;
	logic [ROT_CNT_W-1:0]    i_q;
	logic                    run_q, done_q;

	always_comb begin
		hq = angle + 32'h2000_0000;
		q  = hq[31:30];
		d  = angle - {q, 30'b0};
		x0 = x_in;
		y0 = y_in;
		case (q)
			2'd1: begin
				x0 = -y_in;
				y0 = x_in;
			end
			2'd2: begin
				x0 = -x_in;
				y0 = -y_in;
			end
			2'd3: begin
				x0 = y_in;
				y0 = -x_in;
			end
			default: begin
			end
		endcase
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_entry(5'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= signed'(d);
		end else if (run_q) begin
			if (!z_q[ANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - signed'(at);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + signed'(at);
			end
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign x_out     = x_q;
	assign y_out     = y_q;

endmodule

FILE: rtl/core/encoder_gyro_odometry_update_unit.sv
// Odometry update top level: sequencer, configuration and pose registers.
// Each item runs seven serial products, one after another, on the shared multiplier;
// a result stalled in the output register holds the next result back in S_ACC.
// A new item is taken once the previous one reached the output register.
// Reset: pose and heading clear to zero, gains load their defaults, no item held.
module encoder_gyro_odometry_update_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  odo_pkg::odo_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output odo_pkg::odo_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [odo_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [odo_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import odo_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_INC    = 11'b000_0000_0010,
		S_VX     = 11'b000_0000_0100,
		S_VY     = 11'b000_0000_1000,
		S_ROT_GO = 11'b000_0001_0000,
		S_ROT    = 11'b000_0010_0000,
		S_KX     = 11'b000_0100_0000,
		S_KY     = 11'b000_1000_0000,
		S_PX     = 11'b001_0000_0000,
		S_PY     = 11'b010_0000_0000,
		S_ACC    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [31:0] yaw_gain_q, pulse_length_q;
	logic [15:0] cross_gain_q, yaw_vy_gain_q;

	// Item and working registers.
	logic signed [15:0]      ca_q, cb_q;
	logic signed [23:0]      rate_q;
	logic [ANG_W-1:0]        heading_q;
	logic signed [POS_W-1:0] x_acc_q, y_acc_q;
	logic signed [VEC_W-1:0] vx_q, vy_q, kx_q, ky_q, dx_q, dy_q;

	logic                    out_valid_q;
	odo_out_t                out_q;

	// Shared serial multiplier, and the rotator.
	logic                    mul_start, rot_start;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [PROD_W-1:0]       prod;
	unit_stat_t              mul_st, rot_st;
	logic signed [VEC_W-1:0] rx, ry;

	logic signed [16:0]      diff, sum;
	logic                    neg;
	logic [VEC_W-1:0]        pv;
	logic [47:0]             p48, p48r;
	logic [VEC_W:0]          rmag, rsgn;
	logic                    slot_free, accept;
	logic signed [POS_W:0]   sx, sy;
	logic signed [POS_W-1:0] nx, ny;

	function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] v);
		return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
	endfunction

	function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W:0] s);
		logic signed [POS_W-1:0] r;
		r = s[POS_W-1:0];
		if (!s[POS_W] && s[POS_W-1]) r = {1'b0, {(POS_W-1){1'b1}}};
		else if (s[POS_W] && !s[POS_W-1]) r = {1'b1, {(POS_W-1){1'b0}}};
		return r;
	endfunction

	assign diff = 17'(ca_q) - 17'(cb_q);
	assign sum  = 17'(ca_q) + 17'(cb_q);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	// Sign of the product that just finished, from its signed operand.
	always_comb begin
		unique case (state_q) inside
			S_INC, S_VY: neg = rate_q[23];
			S_VX:        neg = diff[16];
			S_KX:        neg = rx[VEC_W-1];
			S_KY:        neg = ry[VEC_W-1];
			S_PX:        neg = kx_q[VEC_W-1];
			S_PY:        neg = ky_q[VEC_W-1];
			default:     neg = 1'b0;
		endcase
	end

	// Signed low product, and rounding of Q32 products half away from zero.
	assign pv   = neg ? VEC_W'(-prod[VEC_W-1:0]) : prod[VEC_W-1:0];
	assign p48  = neg ? 48'(-prod[47:0]) : prod[47:0];
	assign p48r = p48 + 48'h8000;
	assign rmag = (VEC_W+1)'(prod[PROD_W-1:32]) + (VEC_W+1)'(prod[31]);
	assign rsgn = neg ? (VEC_W+1)'(-rmag) : rmag;

	// Sequencer: start each product as the previous step finishes; the rotation starts from S_ROT_GO.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		rot_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mul_start = 1'b1;
					mul_a     = VEC_W'(mag(VEC_W'(in_data.gyro_rate)));
					mul_b     = yaw_gain_q;
					state_d   = S_INC;
				end
			end
			S_INC: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(VEC_W'(diff));
					mul_b     = MUL_B_W'(cross_gain_q);
					state_d   = S_VX;
				end
			end
			S_VX: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(VEC_W'(rate_q));
					mul_b     = MUL_B_W'(yaw_vy_gain_q);
					state_d   = S_VY;
				end
			end
			S_VY: begin
				if (mul_st.done) state_d = S_ROT_GO;
			end
			S_ROT_GO: begin
				rot_start = 1'b1;
				state_d   = S_ROT;
			end
			S_ROT: begin
				if (rot_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(rx);
					mul_b     = GAIN_COMP;
					state_d   = S_KX;
				end
			end
			S_KX: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(ry);
					mul_b     = GAIN_COMP;
					state_d   = S_KY;
				end
			end
			S_KY: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(kx_q);
					mul_b     = pulse_length_q;
					state_d   = S_PX;
				end
			end
			S_PX: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a     = mag(ky_q);
					mul_b     = pulse_length_q;
					state_d   = S_PY;
				end
			end
			S_PY: begin
				if (mul_st.done) state_d = S_ACC;
			end
			S_ACC: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Saturating position update.
	assign sx = (POS_W+1)'(x_acc_q) + (POS_W+1)'(dx_q);
	assign sy = (POS_W+1)'(y_acc_q) + (POS_W+1)'(dy_q);
	assign nx = sat(sx);
	assign ny = sat(sy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			yaw_gain_q     <= YAW_GAIN_RST;
			cross_gain_q   <= CROSS_GAIN_RST;
			yaw_vy_gain_q  <= YAW_VY_GAIN_RST;
			pulse_length_q <= PULSE_LENGTH_RST;
			heading_q      <= '0;
			x_acc_q        <= '0;
			y_acc_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_YAW_GAIN:     yaw_gain_q     <= cfg_data;
					CFG_CROSS_GAIN:   cross_gain_q   <= cfg_data[15:0];
					CFG_YAW_VY_GAIN:  yaw_vy_gain_q  <= cfg_data[15:0];
					CFG_PULSE_LENGTH: pulse_length_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// Advance the heading by the rounded rate increment.
			if (state_q == S_INC && mul_st.done) heading_q <= heading_q + p48r[47:16];
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == S_ACC && slot_free) begin
				x_acc_q     <= nx;
				y_acc_q     <= ny;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ca_q   <= in_data.count_a;
			cb_q   <= in_data.count_b;
			rate_q <= in_data.gyro_rate;
		end
		if (mul_st.done) begin
			unique case (state_q)
				S_VX:    vx_q <= {pv[VEC_W-9:0], 8'b0};
				S_VY:    vy_q <= pv + {{5{sum[16]}}, sum, 24'b0};
				S_KX:    kx_q <= rsgn[VEC_W-1:0];
				S_KY:    ky_q <= rsgn[VEC_W-1:0];
				S_PX:    dx_q <= rsgn[VEC_W-1:0];
				S_PY:    dy_q <= rsgn[VEC_W-1:0];
				default: begin
				end
			endcase
		end
		if (state_q == S_ACC && slot_free) begin
			out_q.x_pos   <= nx;
			out_q.y_pos   <= ny;
			out_q.heading <= heading_q;
		end
	end

	odo_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_st),
		.prod   (prod)
	);

	odo_cordic u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.angle  (heading_q),
		.x_in   (vx_q),
		.y_in   (vy_q),
		.stat   (rot_st),
		.x_out  (rx),
		.y_out  (ry)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_INC && mul_st.busy))
		else $error("accepted item did not start the rate product");
	a_mul_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_st.busy)
		else $error("multiplier started while busy");
	a_rot_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rot_start |-> !rot_st.busy)
		else $error("rotator started while busy");
	a_rot_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rot_st.done |-> state_q == S_ROT)
		else $error("rotator finished outside its state");
	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && slot_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not posted after accumulation");
`endif

endmodule

FILE: dv/encoder_gyro_odometry_update_unit_test.sv
// Self-checking testbench of the odometry update unit: queued driver, monitor and pose predictor.
`timescale 1ns / 1ps

module encoder_gyro_odometry_update_unit_test;
	import odo_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam longint POS_MAX    = 64'sd140737488355327;
	localparam longint POS_MIN    = -POS_MAX - 1;
	// Indexes past the register list; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	odo_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	odo_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	encoder_gyro_odometry_update_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Mirror of the block's registers and pose.
	logic [31:0] m_yaw_gain, m_pulse_length, m_heading;
	logic [15:0] m_cross_gain, m_yaw_vy_gain;
	longint      m_x, m_y;

	odo_in_t  tick_q[$];
	odo_out_t pose_q[$];
	bit       idle_on = 1'b1;
	bit       hold_send = 1'b0;
	int       errors = 0;
	int       send_gap = 0;
	int       stall_left = 0;
	int       quiet_cycles = 0;

	// round(a * b / 2^32), half away from zero
	function automatic longint scale_q32(input longint a, input logic [31:0] b);
		logic [63:0] mag, lo, hi, r;
		mag = (a < 0) ? -a : a;
		lo  = {32'b0, mag[31:0]} * {32'b0, b};
		hi  = (mag >> 32) * {32'b0, b};
		r   = hi + (lo >> 32) + lo[31];
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint sat_pos(input longint acc, input longint d);
		longint s;
		s = acc + d;
		if (s > POS_MAX) return POS_MAX;
		if (s < POS_MIN) return POS_MIN;
		return s;
	endfunction

	// Advance heading and pose by one tick and return the new pose.
	function automatic odo_out_t advance_pose(input odo_in_t t);
		longint      a, b, rate, inc, vx, vy, tmp, z, xs, ys;
		logic [31:0] d;
		logic [1:0]  quad;
		odo_out_t    p;
		a    = t.count_a;
		b    = t.count_b;
		rate = t.gyro_rate;
		inc  = (rate * longint'({32'b0, m_yaw_gain}) + 32768) >>> 16;
		m_heading = m_heading + inc[31:0];

		vx = (a - b) * longint'({48'b0, m_cross_gain}) * 256;
		vy = (a + b) * 16777216 + rate * longint'({48'b0, m_yaw_vy_gain});

		quad = 2'((m_heading + 32'h2000_0000) >> 30);
		d    = m_heading - {quad, 30'b0};
		z    = longint'(signed'(d));
		case (quad)
			2'd1: begin
				tmp = vx; vx = -vy; vy = tmp;
			end
			2'd2: begin
				vx = -vx; vy = -vy;
			end
			2'd3: begin
				tmp = vx; vx = vy; vy = -tmp;
			end
			default: ;
		endcase

		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (z >= 0) begin
				vx = vx - ys; vy = vy + xs; z = z - longint'({32'b0, atan_entry(5'(i))});
			end else begin
				vx = vx + ys; vy = vy - xs; z = z + longint'({32'b0, atan_entry(5'(i))});
			end
		end

		m_x = sat_pos(m_x, scale_q32(scale_q32(vx, GAIN_COMP), m_pulse_length));
		m_y = sat_pos(m_y, scale_q32(scale_q32(vy, GAIN_COMP), m_pulse_length));
		p.x_pos   = m_x[47:0];
		p.y_pos   = m_y[47:0];
		p.heading = m_heading;
		return p;
	endfunction

	// Driver: present the next tick once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (tick_q.size() > 0 && !hold_send) begin
				in_data  <= tick_q.pop_front();
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					send_gap <= $urandom_range(1, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: predict on every accepted tick, check every accepted pose.
	always @(posedge clk) begin
		odo_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pose_q.push_back(advance_pose(in_data));
			if (out_valid && !out_stall) begin
				if (pose_q.size() == 0) begin
					$error("pose with no tick pending");
					errors++;
				end else begin
					want = pose_q.pop_front();
					if (out_data.x_pos !== want.x_pos) begin
						$error("x_pos expected %0d got %0d", want.x_pos, out_data.x_pos);
						errors++;
					end
					if (out_data.y_pos !== want.y_pos) begin
						$error("y_pos expected %0d got %0d", want.y_pos, out_data.y_pos);
						errors++;
					end
					if (out_data.heading !== want.heading) begin
						$error("heading expected %0d got %0d", want.heading, out_data.heading);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Write one register and mirror it once taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_YAW_GAIN:     m_yaw_gain = val;
			CFG_CROSS_GAIN:   m_cross_gain = val[15:0];
			CFG_YAW_VY_GAIN:  m_yaw_vy_gain = val[15:0];
			CFG_PULSE_LENGTH: m_pulse_length = val;
			default: ;
		endcase
	endtask

	task automatic set_gains(input logic [31:0] yg, input logic [15:0] cg,
			input logic [15:0] vg, input logic [31:0] pl);
		write_reg(CFG_YAW_GAIN, yg);
		write_reg(CFG_CROSS_GAIN, {16'b0, cg});
		write_reg(CFG_YAW_VY_GAIN, {16'b0, vg});
		write_reg(CFG_PULSE_LENGTH, pl);
	endtask

	// Hold until every queued tick is taken and every pose has come back.
	task automatic drain();
		wait (tick_q.size() == 0 && !in_valid && send_gap == 0);
		wait (pose_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic odo_in_t make_tick(input int a, input int b, input int r);
		odo_in_t t;
		t.count_a   = 16'(a);
		t.count_b   = 16'(b);
		t.gyro_rate = 24'(r);
		return t;
	endfunction

	// Mostly plausible motion, sometimes extremes or raw noise.
	function automatic odo_in_t rand_tick();
		odo_in_t t;
		case ($urandom_range(0, 9))
			0: t = odo_in_t'(56'({$urandom, $urandom}));
			1: t = make_tick($urandom_range(0, 1) ? 32767 : -32768,
					$urandom_range(0, 1) ? 32767 : -32768,
					$urandom_range(0, 1) ? 8388607 : -8388608);
			2: t = make_tick(int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 16777215)) - 8388608);
			default: t = make_tick(int'($urandom_range(0, 400)) - 200,
					int'($urandom_range(0, 400)) - 200,
					int'($urandom_range(0, 200000)) - 100000);
		endcase
		return t;
	endfunction

	task automatic run_random(input int n);
		repeat (n) tick_q.push_back(rand_tick());
		drain();
	endtask

	initial begin
		m_yaw_gain     = YAW_GAIN_RST;
		m_cross_gain   = CROSS_GAIN_RST;
		m_yaw_vy_gain  = YAW_VY_GAIN_RST;
		m_pulse_length = PULSE_LENGTH_RST;
		m_heading      = '0;
		m_x            = 0;
		m_y            = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at reset gains: zero, extremes, headings in quadrants 0, 1 and 2.
		tick_q.push_back(make_tick(0, 0, 0));
		tick_q.push_back(make_tick(32767, 32767, 0));
		tick_q.push_back(make_tick(-32768, -32768, 0));
		tick_q.push_back(make_tick(32767, -32768, 8388607));
		tick_q.push_back(make_tick(-32768, 32767, -8388608));
		tick_q.push_back(make_tick(100, 50, 5000000));
		tick_q.push_back(make_tick(100, 50, 5000000));
		tick_q.push_back(make_tick(-1, 1, -1));
		tick_q.push_back(make_tick(1, 1, 1));
		drain();

		// Max gains: drive the pose with full-scale ticks one way, then the other.
		set_gains(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
		repeat (8) tick_q.push_back(make_tick(32767, 32767, 8388607));
		repeat (8) tick_q.push_back(make_tick(-32768, -32768, -8388608));
		tick_q.push_back(make_tick(-32768, 32767, 0));
		drain();
		write_reg(CFG_SPARE_HI, 32'h0000_0000);
		run_random(300);

		// Zero gains: heading and pose must hold.
		set_gains('0, '0, '0, '0);
		tick_q.push_back(make_tick(32767, -32768, 8388607));
		run_random(150);

		// Reset-like gains for a random run.
		set_gains(YAW_GAIN_RST, CROSS_GAIN_RST, YAW_VY_GAIN_RST, PULSE_LENGTH_RST);
		run_random(500);

		set_gains($urandom, 16'($urandom), 16'($urandom), $urandom);
		run_random(400);

		// Final stretch: no idling on either side.
		set_gains(32'h0100_0000, 16'h8000, 16'h0001, 32'h8000_0000);
		idle_on = 1'b0;
		run_random(480);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/odo_pkg.sv
rtl/core/odo_ser_mul.sv
rtl/core/odo_cordic.sv
rtl/core/encoder_gyro_odometry_update_unit.sv
dv/encoder_gyro_odometry_update_unit_test.sv
